// ----- rtl/sfbc_pkg.sv -----
// Shared types and constants for the substitution-table Feistel cipher.
`default_nettype none
package sfbc_pkg;

    localparam int BLOCK_W      = 64;
    localparam int HALF_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int SEL_W        = 4;
    localparam int ENTRY_W      = 8;
    localparam int OP_W         = 2;
    localparam int TBL_ADDR_W   = SEL_W + ENTRY_W;
    localparam int ROUNDS_DEF   = 16;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd1;
    localparam logic [OP_W-1:0] OP_DECRYPT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [SEL_W-1:0]   table_select;
        logic [ENTRY_W-1:0] table_entry;
        logic [BYTE_W-1:0]  table_value;
        logic [BLOCK_W-1:0] block_in;
    } in_item_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_out;
    } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/sfbc_stream_if.sv -----
// Valid/ready channel carrying one item of a given payload type.
`default_nettype none
interface sfbc_stream_if #(
    parameter type T = logic [0:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/sfbc_tables.sv -----
// Substitution table store: one write port, two registered read ports.
`default_nettype none
module sfbc_tables (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [sfbc_pkg::TBL_ADDR_W-1:0]  waddr,
    input  wire logic [sfbc_pkg::BYTE_W-1:0]      wdata,
    input  wire logic [sfbc_pkg::TBL_ADDR_W-1:0]  raddr0,
    input  wire logic [sfbc_pkg::TBL_ADDR_W-1:0]  raddr1,
    output logic      [sfbc_pkg::BYTE_W-1:0]      rdata0,
    output logic      [sfbc_pkg::BYTE_W-1:0]      rdata1
);
    import sfbc_pkg::*;

    localparam int DEPTH = 1 << TBL_ADDR_W;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule
`default_nettype wire

// ----- rtl/sbox_feistel_block_cipher.sv -----
// ROUNDS-round (sixteen by default) substitution-table Feistel cipher, iterative over a shared table store.
// Each round steps through the states RD0, RD1 and FIN on the two table read ports; the
// result is registered when the last round's FIN finds the output slot free.
// No new item is taken until a cipher item has left its last round; a table write item is taken while idle.
// Reset clears the sequencer and the output valid; table contents stay undefined
// until written, and no clearing pass is made.
`default_nettype none
module sbox_feistel_block_cipher #(
    parameter int ROUNDS = sfbc_pkg::ROUNDS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sfbc_stream_if.sink   in_ch,
    sfbc_stream_if.source out_ch
);
    import sfbc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD0  = 2'd1;
    localparam logic [1:0] ST_RD1  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [SEL_W-1:0] LAST_ROUND = SEL_W'(ROUNDS - 1);

    logic [1:0]         state_reg, state_next;
    logic [SEL_W-1:0]   rnd_reg, rnd_next;
    logic               dec_reg, dec_next;
    logic [HALF_W-1:0]  act_reg, act_next;
    logic [HALF_W-1:0]  pas_reg, pas_next;
    logic [15:0]        o01_reg, o01_next;
    logic               out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0] out_block_reg, out_block_next;

    logic                  in_acc;
    logic                  out_free;
    logic [SEL_W-1:0]      tbl;
    logic [BYTE_W-1:0]     s0, s1, s2, s3;
    logic [TBL_ADDR_W-1:0] raddr0, raddr1;
    logic [BYTE_W-1:0]     rdata0, rdata1;
    logic [HALF_W-1:0]     f_val, new_act;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_acc       = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data.block_out = out_block_reg;

    // Decryption walks the tables from the last round down.
    assign tbl = dec_reg ? (LAST_ROUND - rnd_reg) : rnd_reg;

    // Running sums of the active half, from the low byte upward.
    assign s0 = act_reg[7:0];
    assign s1 = s0 + act_reg[15:8];
    assign s2 = s1 + act_reg[23:16];
    assign s3 = s2 + act_reg[31:24];

    // Keep the second pair addressed in the final state so the read data
    // holds while the last round waits for the output slot.
    always_comb
    begin
        if ((state_reg == ST_RD1) || (state_reg == ST_FIN))
        begin
            raddr0 = {tbl, s2};
            raddr1 = {tbl, s3};
        end
        else
        begin
            raddr0 = {tbl, s0};
            raddr1 = {tbl, s1};
        end
    end

    assign f_val   = {o01_reg, rdata0, rdata1};
    assign new_act = pas_reg ^ f_val;

    sfbc_tables u_tables (
        .clk    (clk),
        .we     (in_acc && (in_ch.data.opcode == OP_WRITE)),
        .waddr  ({in_ch.data.table_select, in_ch.data.table_entry}),
        .wdata  (in_ch.data.table_value),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        dec_next       = dec_reg;
        act_next       = act_reg;
        pas_next       = pas_reg;
        o01_next       = o01_reg;
        out_valid_next = out_valid_reg;
        out_block_next = out_block_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_ch.data.opcode == OP_ENCRYPT))
                begin
                    dec_next   = 1'b0;
                    act_next   = in_ch.data.block_in[HALF_W-1:0];
                    pas_next   = in_ch.data.block_in[BLOCK_W-1:HALF_W];
                    rnd_next   = '0;
                    state_next = ST_RD0;
                end
                else if (in_acc && (in_ch.data.opcode == OP_DECRYPT))
                begin
                    dec_next   = 1'b1;
                    act_next   = in_ch.data.block_in[BLOCK_W-1:HALF_W];
                    pas_next   = in_ch.data.block_in[HALF_W-1:0];
                    rnd_next   = '0;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                o01_next   = {rdata0, rdata1};
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (rnd_reg != LAST_ROUND)
                begin
                    act_next   = new_act;
                    pas_next   = act_reg;
                    rnd_next   = rnd_reg + 1'b1;
                    state_next = ST_RD0;
                end
                else if (out_free)
                begin
                    // Hold the last round until the output slot is free.
                    out_valid_next = 1'b1;
                    out_block_next = dec_reg ? {new_act, act_reg} : {act_reg, new_act};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg       <= dec_next;
        act_reg       <= act_next;
        pas_reg       <= pas_next;
        o01_reg       <= o01_next;
        out_block_reg <= out_block_next;
    end

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the substitution-table Feistel cipher: table loads, cipher items, stalls.
module tb;
    import sfbc_pkg::*;

    localparam int CIPHER_ROUNDS = ROUNDS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 650;
    localparam int TAIL_ITEMS = 120;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 3 * CIPHER_ROUNDS + 12;
    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n;

    sfbc_stream_if #(.T(in_item_t))  in_ch ();
    sfbc_stream_if #(.T(out_item_t)) out_ch ();

    sbox_feistel_block_cipher u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // Table contents as the block should hold them, updated on acceptance.
    logic [BYTE_W-1:0] sbox_image [1 << TBL_ADDR_W];
    logic [BLOCK_W-1:0] expected_blocks [$];
    in_item_t pending_items [$];

    int total_items;
    int items_taken;
    int blocks_seen;
    int mismatches;
    int src_gap;
    int sink_hold;
    int cycle_count;
    bit long_hold_done;
    bit quiet_tail;
    logic [BLOCK_W-1:0] wanted_block;

    function automatic logic [HALF_W-1:0] round_mix(input logic [HALF_W-1:0] half,
                                                    input logic [SEL_W-1:0] tsel);
        logic [BYTE_W-1:0] acc;
        logic [HALF_W-1:0] mixed;
        acc = half[7:0];
        mixed[31:24] = sbox_image[{tsel, acc}];
        acc = acc + half[15:8];
        mixed[23:16] = sbox_image[{tsel, acc}];
        acc = acc + half[23:16];
        mixed[15:8] = sbox_image[{tsel, acc}];
        acc = acc + half[31:24];
        mixed[7:0] = sbox_image[{tsel, acc}];
        return mixed;
    endfunction

    function automatic logic [BLOCK_W-1:0] feistel_predict(input logic [BLOCK_W-1:0] blk,
                                                           input bit decipher);
        logic [HALF_W-1:0] lh;
        logic [HALF_W-1:0] rh;
        logic [HALF_W-1:0] keep;
        lh = blk[63:32];
        rh = blk[31:0];
        for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            if (!decipher) begin
                keep = rh;
                rh = lh ^ round_mix(rh, SEL_W'(r));
                lh = keep;
            end else begin
                keep = lh;
                lh = rh ^ round_mix(lh, SEL_W'(CIPHER_ROUNDS - 1 - r));
                rh = keep;
            end
        end
        return {lh, rh};
    endfunction

    function automatic logic [BLOCK_W-1:0] rand_block();
        logic [HALF_W-1:0] halves [2];
        for (int h = 0; h < 2; h++) begin
            case ($urandom_range(0, 9))
                0:       halves[h] = '0;
                1:       halves[h] = '1;
                default: halves[h] = $urandom;
            endcase
        end
        return {halves[0], halves[1]};
    endfunction

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                              input logic [ENTRY_W-1:0] ent, input logic [BYTE_W-1:0] val,
                              input logic [BLOCK_W-1:0] blk);
        in_item_t it;
        it.opcode = op;
        it.table_select = sel;
        it.table_entry = ent;
        it.table_value = val;
        it.block_in = blk;
        pending_items.push_back(it);
    endtask

    task automatic queue_write(input logic [SEL_W-1:0] sel, input logic [ENTRY_W-1:0] ent,
                               input logic [BYTE_W-1:0] val);
        queue_item(OP_WRITE, sel, ent, val, {$urandom, $urandom});
    endtask

    task automatic queue_cipher(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] blk);
        queue_item(op, SEL_W'($urandom), ENTRY_W'($urandom), BYTE_W'($urandom), blk);
    endtask

    task automatic apply_item(input in_item_t it);
        case (it.opcode)
            OP_WRITE:   sbox_image[{it.table_select, it.table_entry}] = it.table_value;
            OP_ENCRYPT: expected_blocks.push_back(feistel_predict(it.block_in, 1'b0));
            OP_DECRYPT: expected_blocks.push_back(feistel_predict(it.block_in, 1'b1));
            default:    ;
        endcase
    endtask

    // Driver: offer the head of the pending queue, with random gaps.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            src_gap = 0;
            quiet_tail <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                apply_item(in_ch.data);
                pending_items.delete(0);
                items_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 3);
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_items[0];
                end
            end
            quiet_tail <= (pending_items.size() < TAIL_ITEMS);
        end
    end

    // Receiver: random stall bursts plus one long hold to back the block up.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            sink_hold = 0;
            long_hold_done = 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            out_ch.ready <= 1'b0;
        end else if (!long_hold_done && blocks_seen >= 30) begin
            long_hold_done = 1'b1;
            sink_hold = LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(0, 3);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor: compare each accepted block with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            blocks_seen++;
            if (expected_blocks.size() == 0) begin
                $error("block_out: expected none, actual %h", out_ch.data.block_out);
                mismatches++;
            end else begin
                wanted_block = expected_blocks.pop_front();
                if (out_ch.data.block_out !== wanted_block) begin
                    $error("block_out: expected %h, actual %h", wanted_block,
                           out_ch.data.block_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        items_taken = 0;
        blocks_seen = 0;
        mismatches = 0;
        cycle_count = 0;

        // Load every table entry before any cipher item can read it.
        for (int a = 0; a < (1 << TBL_ADDR_W); a++)
            queue_write(SEL_W'(a >> ENTRY_W), ENTRY_W'(a), BYTE_W'($urandom));

        // Directed: extreme bytes, all-zero and all-one blocks, ignored fields.
        queue_write(4'd0, 8'd0, 8'h00);
        queue_write(4'd15, 8'd255, 8'hFF);
        queue_write(4'd7, 8'h80, 8'h5A);
        queue_cipher(OP_ENCRYPT, 64'h0);
        queue_cipher(OP_ENCRYPT, '1);
        queue_cipher(OP_DECRYPT, 64'h0);
        queue_cipher(OP_DECRYPT, '1);
        queue_cipher(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
        queue_cipher(OP_DECRYPT, 64'h0123_4567_89AB_CDEF);
        queue_cipher(OP_ENCRYPT, 64'h0000_0000_FFFF_FFFF);
        queue_cipher(OP_DECRYPT, 64'hFFFF_FFFF_0000_0000);
        // unused opcode must neither write nor answer
        queue_item(OP_UNUSED, 4'd0, 8'd0, 8'hFF, '1);
        queue_item(OP_UNUSED, 4'd15, 8'd255, 8'h00, 64'h0);
        queue_cipher(OP_ENCRYPT, 64'h0);
        // write carries a full block_in that must be dropped
        queue_item(OP_WRITE, 4'd0, 8'd0, 8'hFF, '1);
        queue_item(OP_ENCRYPT, '1, '1, '1, 64'h0);
        queue_item(OP_DECRYPT, '0, '0, '0, 64'h0);
        queue_write(4'd15, 8'd0, 8'h00);
        queue_cipher(OP_DECRYPT, '1);
        queue_cipher(OP_ENCRYPT, rand_block());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 99)) inside
                [0:39]:  queue_cipher(OP_ENCRYPT, rand_block());
                [40:74]: queue_cipher(OP_DECRYPT, rand_block());
                [75:93]: queue_write(SEL_W'($urandom), ENTRY_W'($urandom), BYTE_W'($urandom));
                default: queue_item(OP_UNUSED, SEL_W'($urandom), ENTRY_W'($urandom),
                                    BYTE_W'($urandom), {$urandom, $urandom});
            endcase
        end
        total_items = pending_items.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_taken < total_items)
            @(posedge clk);
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sbox_feistel_block_cipher.f -----
rtl/sfbc_pkg.sv
rtl/sfbc_stream_if.sv
rtl/sfbc_tables.sv
rtl/sbox_feistel_block_cipher.sv
test/tb.sv
